// File: hdl/gn3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, types and arithmetic helpers of the 3-D gradient noise.
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int PERM_W     = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int OUT_W      = 16;
  localparam int OUT_SHIFT  = FRAC_BITS - 15;
  localparam int OUT_MAX    = (1 << OUT_W) - 1;

  localparam bit FUNC_LOAD = 1'b0;
  localparam bit FUNC_EVAL = 1'b1;

  typedef logic [PERM_W-1:0]                perm_t;
  typedef logic [FRAC_BITS-1:0]             frac_t;
  typedef logic [FRAC_BITS:0]               fade_t;
  typedef logic [2:0][FRAC_BITS-1:0]        frac3_t;
  typedef logic [2:0][FRAC_BITS:0]          fade3_t;
  typedef logic [7:0][PERM_W-1:0]           hash8_t;
  typedef logic signed [FRAC_BITS+4:0]      val_t;
  typedef logic signed [FRAC_BITS+5:0]      wide_t;

  typedef struct packed {
    logic  valid;
    perm_t index;
    perm_t value;
  } load_t;

  function automatic val_t grad_fx(input logic [3:0] h, input val_t x, input val_t y,
                                   input val_t z);
    val_t u;
    val_t v;
    u = h[3] ? y : x;
    if (!h[3] && !h[2]) begin
      v = y;
    end else if (h inside {4'd12, 4'd14}) begin
      v = x;
    end else begin
      v = z;
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic val_t lerp_fx(input fade_t w, input val_t a, input val_t b);
    wide_t                      d;
    logic signed [2*FRAC_BITS+7:0] p;
    d = b - a;
    p = $signed({1'b0, w}) * d;
    return a + val_t'(p >>> FRAC_BITS);
  endfunction

endpackage

// File: hdl/gradient_noise_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Takes one transaction per cycle while the output is not stalled, a rate
// set by the hash levels each reading their own copies of the permutation
// table. Load transactions give no output.
// Reset clears the pipeline valid bits; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_3d (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [7:0]            perm_index,
  input  logic [7:0]            perm_value,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  input  logic signed [31:0]    coord_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           noise_value
);
  import gn3_pkg::*;

  logic        en;
  logic [8:1]  vld;
  logic [8:1]  evl;
  perm_t       idx1, pval1, cx1, cy1, cz1;
  frac3_t      t1, t2d, t3d, t4d;
  fade3_t      fade4;
  hash8_t      hash4;
  load_t       wr1;
  val_t        n8;
  wide_t       r;
  wide_t       sc;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[7:1], in_valid};
      out_valid <= vld[8] && evl[8];
    end
    if (en) begin
      evl   <= {evl[7:1], func == FUNC_EVAL};
      idx1  <= perm_index;
      pval1 <= perm_value;
      cx1   <= coord_x[FRAC_BITS+PERM_W-1:FRAC_BITS];
      cy1   <= coord_y[FRAC_BITS+PERM_W-1:FRAC_BITS];
      cz1   <= coord_z[FRAC_BITS+PERM_W-1:FRAC_BITS];
      t1[0] <= coord_x[FRAC_BITS-1:0];
      t1[1] <= coord_y[FRAC_BITS-1:0];
      t1[2] <= coord_z[FRAC_BITS-1:0];
      t2d   <= t1;
      t3d   <= t2d;
      t4d   <= t3d;
      if (vld[8] && evl[8]) begin
        if (r <= 0) begin
          noise_value <= '0;
        end else if (sc > wide_t'(OUT_MAX)) begin
          noise_value <= OUT_W'(OUT_MAX);
        end else begin
          noise_value <= sc[OUT_W-1:0];
        end
      end
    end
  end

  assign wr1.valid = vld[1] && (evl[1] == FUNC_LOAD);
  assign wr1.index = idx1;
  assign wr1.value = pval1;

  gn3_hash u_hash (
    .clk(clk), .rst(rst), .en(en), .wr(wr1),
    .cx(cx1), .cy(cy1), .cz(cz1), .hash(hash4)
  );

  gn3_fade u_fade (
    .clk(clk), .en(en), .t_in(t1), .fade_out(fade4)
  );

  gn3_interp u_interp (
    .clk(clk), .en(en), .hash(hash4), .t_in(t4d), .fade_in(fade4), .n_out(n8)
  );

  assign r  = wide_t'(n8) + wide_t'(ONE);
  assign sc = r >>> OUT_SHIFT;

endmodule

// File: hdl/gn3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hdl/gn3_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_fade
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 for all three axes.
// ----------------------------------------------------------------------------
module gn3_fade (
  input  logic            clk,
  input  logic            en,
  input  gn3_pkg::frac3_t t_in,
  output gn3_pkg::fade3_t fade_out
);
  import gn3_pkg::*;

  frac3_t t2_t;
  frac3_t t2;
  frac3_t t3;
  logic [2:0][FRAC_BITS+4:0] poly;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t2_t[i]     <= t_in[i];
        t2[i]       <= frac_t'((2*FRAC_BITS)'(t_in[i]) * (2*FRAC_BITS)'(t_in[i]) >> FRAC_BITS);
        t3[i]       <= frac_t'((2*FRAC_BITS)'(t2[i]) * (2*FRAC_BITS)'(t2_t[i]) >> FRAC_BITS);
        poly[i]     <= (FRAC_BITS+5)'(t2[i]) * (FRAC_BITS+5)'(6)
                     + (FRAC_BITS+5)'(10*ONE)
                     - (FRAC_BITS+5)'(t2_t[i]) * (FRAC_BITS+5)'(15);
        fade_out[i] <= fade_t'(((2*FRAC_BITS+5)'(t3[i]) * (2*FRAC_BITS+5)'(poly[i]))
                               >> FRAC_BITS);
      end
    end
  end

endmodule

// File: hdl/gn3_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_hash
// Three-level permutation hash over replicated table copies, one level a stage.
// ----------------------------------------------------------------------------
module gn3_hash (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  gn3_pkg::load_t wr,
  input  gn3_pkg::perm_t cx,
  input  gn3_pkg::perm_t cy,
  input  gn3_pkg::perm_t cz,
  output gn3_pkg::hash8_t hash
);
  import gn3_pkg::*;

  load_t wr2, wr3;
  perm_t cy2, cz2, cz3;
  perm_t p1 [2];
  perm_t p2 [4];
  perm_t a1 [2];
  perm_t a2 [4];
  perm_t a3 [8];
  perm_t pa, pb;

  // Table writes follow the load transaction down the pipeline, so each level
  // sees loads and evaluations in their order of arrival.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr2.valid <= 1'b0;
      wr3.valid <= 1'b0;
    end else if (en) begin
      wr2.valid <= wr.valid;
      wr3.valid <= wr2.valid;
    end
    if (en) begin
      wr2.index <= wr.index;
      wr2.value <= wr.value;
      wr3.index <= wr2.index;
      wr3.value <= wr2.value;
      cy2 <= cy;
      cz2 <= cz;
      cz3 <= cz2;
    end
  end

  assign a1[0] = cx;
  assign a1[1] = cx + perm_t'(1);
  assign pa    = p1[0] + cy2;
  assign pb    = p1[1] + cy2;
  assign a2[0] = pa;
  assign a2[1] = pa + perm_t'(1);
  assign a2[2] = pb;
  assign a2[3] = pb + perm_t'(1);
  assign a3[0] = p2[0] + cz3;
  assign a3[1] = p2[2] + cz3;
  assign a3[2] = p2[1] + cz3;
  assign a3[3] = p2[3] + cz3;
  assign a3[4] = p2[0] + cz3 + perm_t'(1);
  assign a3[5] = p2[2] + cz3 + perm_t'(1);
  assign a3[6] = p2[1] + cz3 + perm_t'(1);
  assign a3[7] = p2[3] + cz3 + perm_t'(1);

  for (genvar i = 0; i < 2; i++) begin : g_l1
    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk(clk), .we(en && wr.valid), .waddr(wr.index), .wdata(wr.value),
      .re(en), .raddr(a1[i]), .rdata(p1[i])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_l2
    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk(clk), .we(en && wr2.valid), .waddr(wr2.index), .wdata(wr2.value),
      .re(en), .raddr(a2[i]), .rdata(p2[i])
    );
  end

  for (genvar i = 0; i < 8; i++) begin : g_l3
    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk(clk), .we(en && wr3.valid), .waddr(wr3.index), .wdata(wr3.value),
      .re(en), .raddr(a3[i]), .rdata(hash[i])
    );
  end

endmodule

// File: hdl/gn3_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_interp
// Corner gradients followed by three registered levels of linear interpolation.
// ----------------------------------------------------------------------------
module gn3_interp (
  input  logic            clk,
  input  logic            en,
  input  gn3_pkg::hash8_t hash,
  input  gn3_pkg::frac3_t t_in,
  input  gn3_pkg::fade3_t fade_in,
  output gn3_pkg::val_t   n_out
);
  import gn3_pkg::*;

  val_t  r0 [3];
  val_t  r1 [3];
  val_t  c5 [8];
  val_t  x6 [4];
  val_t  y7 [2];
  fade_t fu5, fv5, fw5, fv6, fw6, fw7;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign r0[i] = val_t'({1'b0, t_in[i]});
    assign r1[i] = r0[i] - val_t'(ONE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        c5[k] <= grad_fx(hash[k][3:0], k[0] ? r1[0] : r0[0], k[1] ? r1[1] : r0[1],
                         k[2] ? r1[2] : r0[2]);
      end
      fu5 <= fade_in[0];
      fv5 <= fade_in[1];
      fw5 <= fade_in[2];
      for (int k = 0; k < 4; k++) begin
        x6[k] <= lerp_fx(fu5, c5[2*k], c5[2*k+1]);
      end
      fv6 <= fv5;
      fw6 <= fw5;
      for (int k = 0; k < 2; k++) begin
        y7[k] <= lerp_fx(fv6, x6[2*k], x6[2*k+1]);
      end
      fw7 <= fw6;
      n_out <= lerp_fx(fw7, y7[0], y7[1]);
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3-D gradient noise block. The permutation table
// is loaded first, then a short table of directed points and reloads and
// random traffic (points mixed with table reloads) is checked against an
// in-bench predictor or fixed values, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb;
  import gn3_pkg::*;

  typedef struct {
    bit          fn;
    logic [7:0]  idx;
    logic [7:0]  pv;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          has_lit;
    logic [15:0] lit;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_LOAD;
  logic [7:0] perm_index = '0;
  logic [7:0] perm_value = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] noise_value;

  logic [7:0] perm_copy [256];
  logic [15:0] noise_queue [$];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;
  stim_t directed [$];

  gradient_noise_3d dut (.*);

  always #10 clk = ~clk;

  function automatic longint fade_of(longint t);
    longint t2;
    longint t3;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    return (t3 * (6 * t2 + 10 * 65536 - 15 * t)) >>> 16;
  endfunction

  function automatic longint blend(longint w, longint a, longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic longint corner(logic [7:0] hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint u;
    longint v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    if (h < 4) v = y;
    else if (h == 12 || h == 14) v = x;
    else v = z;
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] cz;
    logic [7:0] a;
    logic [7:0] aa;
    logic [7:0] ab;
    logic [7:0] b;
    logic [7:0] ba;
    logic [7:0] bb;
    longint rx;
    longint ry;
    longint rz;
    longint u;
    longint v;
    longint w;
    longint c [8];
    longint y1;
    longint y2;
    longint r;
    cx = px[23:16];
    cy = py[23:16];
    cz = pz[23:16];
    rx = longint'(px[15:0]);
    ry = longint'(py[15:0]);
    rz = longint'(pz[15:0]);
    u = fade_of(rx);
    v = fade_of(ry);
    w = fade_of(rz);
    a = perm_copy[cx] + cy;
    aa = perm_copy[a] + cz;
    ab = perm_copy[8'(a + 1)] + cz;
    b = perm_copy[8'(cx + 1)] + cy;
    ba = perm_copy[b] + cz;
    bb = perm_copy[8'(b + 1)] + cz;
    c[0] = corner(perm_copy[aa], rx, ry, rz);
    c[1] = corner(perm_copy[ba], rx - 65536, ry, rz);
    c[2] = corner(perm_copy[ab], rx, ry - 65536, rz);
    c[3] = corner(perm_copy[bb], rx - 65536, ry - 65536, rz);
    c[4] = corner(perm_copy[8'(aa + 1)], rx, ry, rz - 65536);
    c[5] = corner(perm_copy[8'(ba + 1)], rx - 65536, ry, rz - 65536);
    c[6] = corner(perm_copy[8'(ab + 1)], rx, ry - 65536, rz - 65536);
    c[7] = corner(perm_copy[8'(bb + 1)], rx - 65536, ry - 65536, rz - 65536);
    y1 = blend(v, blend(u, c[0], c[1]), blend(u, c[2], c[3]));
    y2 = blend(v, blend(u, c[4], c[5]), blend(u, c[6], c[7]));
    r = blend(w, y1, y2) + 65536;
    if (r <= 0) return 16'd0;
    r = r >>> 1;
    return (r > 65535) ? 16'hFFFF : 16'(r);
  endfunction

  task automatic send(stim_t s);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    func <= s.fn;
    perm_index <= s.idx;
    perm_value <= s.pv;
    coord_x <= s.x;
    coord_y <= s.y;
    coord_z <= s.z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (s.fn == FUNC_LOAD) begin
      perm_copy[s.idx] = s.pv;
    end else if (s.has_lit) begin
      noise_queue.push_back(s.lit);
    end else begin
      noise_queue.push_back(noise_at(s.x, s.y, s.z));
    end
    @(negedge clk);
  endtask

  function automatic stim_t point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    stim_t s;
    s = '{FUNC_EVAL, 8'($urandom), 8'($urandom), x, y, z, 1'b0, 16'd0};
    return s;
  endfunction

  function automatic stim_t loader(logic [7:0] i, logic [7:0] v);
    stim_t s;
    s = '{FUNC_LOAD, i, v, $urandom, $urandom, $urandom, 1'b0, 16'd0};
    return s;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: done, errors");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (noise_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", noise_value);
      end else begin
        logic [15:0] want;
        want = noise_queue.pop_front();
        if (want !== noise_value) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("noise_value mismatch: expected %h actual %h", want, noise_value);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

  initial begin
    stim_t s;
    logic [7:0] shuffle [256];
    int j;
    logic [7:0] tmp;
    int wait_n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end
    for (int i = 0; i < 256; i++) send(loader(8'(i), shuffle[i]));
    // With zero fraction on every axis only the origin corner counts, and its
    // gradient term is zero, so the output is one half.
    s = point(32'h0, 32'h0, 32'h0);
    s.has_lit = 1'b1;
    s.lit = 16'h8000;
    directed.push_back(s);
    s = point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    s.has_lit = 1'b1;
    s.lit = 16'h8000;
    directed.push_back(s);
    s = point(32'h7FFF_0000, 32'hFFFF_0000, 32'h00FF_0000);
    s.has_lit = 1'b1;
    s.lit = 16'h8000;
    directed.push_back(s);
    directed.push_back(point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(point(32'h0000_FFFF, 32'h0000_0001, 32'h0000_8000));
    directed.push_back(point(32'h00FF_FFFF, 32'h0000_8000, 32'hFF00_0001));
    directed.push_back(point(32'hFFFF_8000, 32'h0001_8000, 32'hAAAA_5555));
    directed.push_back(point(32'h5555_AAAA, 32'hFFFF_7FFF, 32'h8000_FFFF));
    directed.push_back(loader(8'hFF, shuffle[8'hFF]));
    directed.push_back(loader(8'h00, shuffle[8'h00]));
    foreach (directed[k]) send(directed[k]);
    for (int k = 0; k < 1280; k++) begin
      calm = (k >= 600 && k < 800);
      if (k == 1000) begin
        in_valid <= 1'b0;
        while (noise_queue.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if ($urandom_range(99) < 8) begin
        j = $urandom_range(255);
        send(loader(8'(j), 8'($urandom)));
      end else begin
        send(point($urandom, $urandom, $urandom));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    wait_n = 0;
    while (noise_queue.size() != 0 && wait_n < 20000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (30) @(posedge clk);
    if (mismatches == 0 && noise_queue.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
